[rtl/url_dec_pkg.sv]
// shared types, codes and character helpers for the url percent decoder
package url_dec_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam int unsigned CMD_DEPTH = 4;     // default command queue depth

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_PLAIN    = 2'd0,   // emit plain(data) with last
    OP_ESCAPE   = 2'd1,   // emit escape value of (held, data) with last
    OP_PCT_LAST = 2'd2,   // emit '%' marked last
    OP_PCT_PAIR = 2'd3    // emit '%' then plain(data) marked last
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] held;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic valid;   // head entry present
    logic full;    // no room for a push
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
    hex_t ha;
    hex_t hb;
    logic [7:0] r;
    ha = hex_val(a);
    hb = hex_val(b);
    r  = 8'd0;
    if (ha.ok) begin
      r = hb.ok ? {ha.val, hb.val} : {4'd0, ha.val};
    end else if (hb.ok) begin
      if (is_blank(a) || a == CH_PLUS) begin
        r = {4'd0, hb.val};
      end else if (a == CH_MINUS) begin
        r = 8'(-{4'd0, hb.val});
      end
    end
    return r;
  endfunction

endpackage

[rtl/url_dec_front.sv]
// front end: accepts input items, tracks the escape phase and pushes commands
module url_dec_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 q_full,
  output logic                 in_ready,
  output logic                 push,
  output url_dec_pkg::cmd_t    push_cmd
);
  import url_dec_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       emit;
  logic       take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'd0;
    end else begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    held_next     = held;
    emit          = 1'b0;
    push_cmd.op   = OP_PLAIN;
    push_cmd.held = held;
    push_cmd.data = in_byte;
    push_cmd.last = in_last;
    case (phase)
      PH_PCT: begin
        if (in_last) begin
          emit        = 1'b1;
          push_cmd.op = OP_PCT_PAIR;
          phase_next  = PH_IDLE;
        end else begin
          held_next  = in_byte;
          phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        emit        = 1'b1;
        push_cmd.op = OP_ESCAPE;
        phase_next  = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (in_byte == CH_PERCENT) begin
          if (in_last) begin
            emit        = 1'b1;
            push_cmd.op = OP_PCT_LAST;
          end else begin
            phase_next = PH_PCT;
          end
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (!take) begin
      phase_next = phase;
      held_next  = held;
    end
  end

endmodule

[rtl/url_dec_fifo.sv]
// short command queue between front and back
module url_dec_fifo #(
  parameter int unsigned DEPTH = url_dec_pkg::CMD_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  url_dec_pkg::cmd_t    push_cmd,
  input  logic                 pop,
  output url_dec_pkg::cmd_t    head,
  output url_dec_pkg::q_stat_t stat
);
  import url_dec_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("command queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty command queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != CW'(DEPTH)) else $error("push into full command queue");
`endif

endmodule

[rtl/url_dec_back.sv]
// back end: executes queued commands into the output register
module url_dec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  url_dec_pkg::cmd_t    head,
  input  url_dec_pkg::q_stat_t stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import url_dec_pkg::*;

  logic       load;
  logic       second;
  logic       second_next;
  logic [7:0] byte_next;
  logic       last_next;

  assign load = !out_valid || out_ready;

  always_comb begin
    second_next = second;
    pop         = 1'b0;
    byte_next   = plain(head.data);
    last_next   = head.last;
    case (head.op)
      OP_ESCAPE: begin
        byte_next = escape_value(head.held, head.data);
      end
      OP_PCT_LAST: begin
        byte_next = CH_PERCENT;
        last_next = 1'b1;
      end
      OP_PCT_PAIR: begin
        if (!second) begin
          byte_next = CH_PERCENT;
          last_next = 1'b0;
        end else begin
          last_next = 1'b1;
        end
      end
      default: begin
        byte_next = plain(head.data);
      end
    endcase
    if (load && stat.valid) begin
      if (head.op == OP_PCT_PAIR && !second) begin
        second_next = 1'b1;
      end else begin
        second_next = 1'b0;
        pop         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      second <= second_next;
      if (load) begin
        out_valid <= stat.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && stat.valid) begin
      out_byte <= byte_next;
      out_last <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_second_on_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> stat.valid && head.op == OP_PCT_PAIR) else $error("split step without pair");
  a_pair_first_not_last: assert property (@(posedge clk) disable iff (rst)
    $rose(second) |-> out_valid && !out_last) else $error("leading percent marked last");
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid) else $error("popped command produced no item");
`endif

endmodule

[rtl/url_percent_decoder.sv]
// top level of the streaming form url decoder
//
//  channel | dir | handshake         | contents
//  --------+-----+-------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata[7:0] in_byte, s_tlast in_last
//  m_*     | out | m_tvalid/m_tready | m_tdata[7:0] out_byte, m_tlast out_last
//
// one input item per cycle sustained while the command queue has room; an item's
//   command is queued at its accept edge and moves into the output register when that loads
// a percent with its last byte right behind it yields two output items, which
//   pass one after the other through the single output register
// rst is synchronous, active high; it clears the escape phase, the queue and
//   the output valid
// the front stalls only when the command queue is full, so a stalled output
//   still lets DEPTH commands queue up behind the item held in the output register
module url_percent_decoder #(
  parameter int unsigned DEPTH = url_dec_pkg::CMD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);
  import url_dec_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;
  q_stat_t stat;

  // escape tracking and command generation
  url_dec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (stat.full),
    .in_ready (s_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples accept from output backpressure
  url_dec_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // value computation and output register
  url_dec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

[dv/tb.sv]
// testbench for the streaming form url decoder: directed and random strings
`timescale 1ns / 1ps

module tb;
  import url_dec_pkg::*;

  localparam int CLK_HALF   = 6;      // 12 ns clock
  localparam int IDLE_LIMIT = 3000;   // cycles with no item moving on either side
  localparam int HOLD_LEN   = 250;    // long receiver hold-off in the pressure test
  localparam int DRAIN_WAIT = 20;     // cycles after the last expected item
  localparam int ITEM_GOAL  = 1550;

  // one decoded character as the block should hand it out
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } dec_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;

  // decoder state as the testbench sees it
  phase_t     esc_phase = PH_IDLE;
  logic [7:0] first_digit = 8'h00;

  dec_char_t  decoded_q[$];      // decoded characters still owed by the block
  int         mismatches = 0;
  int         chars_sent = 0;
  int         idle_cycles = 0;
  int         hold_left = 0;     // set by the pressure test, counted down by the receiver
  int         stall_left = 0;
  bit         steady = 1'b0;     // no sender gaps and no random receiver stalls while set

  url_percent_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  // what a base-16 text-to-integer parse of the two characters gives, cut to a byte
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] na;
    logic [4:0] nb;
    na = hex_nibble(a);
    nb = hex_nibble(b);
    if (na[4]) return nb[4] ? {na[3:0], nb[3:0]} : {4'h0, na[3:0]};
    if (!nb[4]) return 8'h00;
    // leading blank or sign, then a single digit
    if (a == CH_SPACE || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS) return {4'h0, nb[3:0]};
    if (a == CH_MINUS) return 8'(9'd256 - {5'd0, nb[3:0]});
    return 8'h00;
  endfunction

  function automatic logic [7:0] unplus(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  // advance the escape state by one accepted input item and queue what it yields
  function automatic void decode_step(input logic [7:0] c, input logic fin);
    case (esc_phase)
      PH_PCT: begin
        if (fin) begin
          // string ends on the byte after the percent: percent goes out literally, then that byte
          decoded_q.push_back('{CH_PERCENT, 1'b0});
          decoded_q.push_back('{unplus(c), 1'b1});
          esc_phase = PH_IDLE;
        end else begin
          first_digit = c;
          esc_phase = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        decoded_q.push_back('{pair_value(first_digit, c), fin});
        esc_phase = PH_IDLE;
      end
      default: begin
        esc_phase = PH_IDLE;
        if (c == CH_PERCENT) begin
          if (fin) decoded_q.push_back('{CH_PERCENT, 1'b1});
          else esc_phase = PH_PCT;
        end else begin
          decoded_q.push_back('{unplus(c), fin});
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // offer one item and return on the edge that accepts it
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    decode_step(c, fin);
    chars_sent++;
  endtask

  // send a whole string, last mark on its final character
  task automatic send_string(input logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t ns: mismatch on %s: expected %02h, got %02h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : rx_side
    dec_char_t want;
    int r;
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected item", 8'h00, m_tdata);
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata !== want.ch) report_mismatch("out_byte", want.ch, m_tdata);
        if (m_tlast !== want.fin) begin
          report_mismatch("out_last", {7'd0, want.fin}, {7'd0, m_tlast});
        end
      end
    end
    // ready pattern: forced hold-off first, then steady mode, then random stalls
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 75) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(2, 0) : $urandom_range(40, 10);
        m_tready <= 1'b0;
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // byte extremes, plus sign, escape rules, percent near the end of a string
  task automatic test_directed();
    send_string('{8'h00, 8'hFF});
    send_string('{CH_PLUS});
    send_string('{CH_PERCENT, "4", "A"});        // two hex digits
    send_string('{CH_PERCENT, "f", "G"});        // hex then non-hex
    send_string('{CH_PERCENT, CH_TAB, "c"});     // blank then digit
    send_string('{CH_PERCENT, CH_PLUS, "9"});    // plus sign then digit
    send_string('{CH_PERCENT, CH_MINUS, "1"});   // minus then digit wraps
    send_string('{CH_PERCENT, "z", "z"});        // no digit at all
    send_string('{CH_PERCENT});                  // percent as the last byte
    send_string('{CH_PERCENT, CH_PLUS});         // last byte right after a percent
  endtask

  // a character likely to sit after a percent
  function automatic logic [7:0] escape_char();
    int r;
    logic [7:0] hex_set[22];
    hex_set = '{"0","1","2","3","4","5","6","7","8","9",
                "a","b","c","d","e","f","A","B","C","D","E","F"};
    r = $urandom_range(99);
    if (r < 50) return hex_set[$urandom_range(21)];
    if (r < 60) return (r < 55) ? CH_SPACE : 8'($urandom_range(CH_CR, CH_TAB));
    if (r < 70) return CH_PLUS;
    if (r < 80) return CH_MINUS;
    return 8'($urandom);
  endfunction

  task automatic send_random_string(input int len, input bit noise);
    logic [7:0] text[$];
    int r;
    while (text.size() < len) begin
      r = $urandom_range(99);
      if (noise || r >= 60) begin
        text.push_back(8'($urandom));
      end else if (r < 40) begin
        text.push_back(CH_PERCENT);
        text.push_back(escape_char());
        text.push_back(escape_char());
      end else if (r < 52) begin
        text.push_back(CH_PLUS);
      end else begin
        text.push_back(CH_PERCENT);               // a percent with too few digits
      end
    end
    // an escape that runs past the end is cut short, giving the early-end cases
    while (text.size() > len) void'(text.pop_back());
    send_string(text);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    logic [7:0] text[$];
    steady = 1'b1;
    hold_left = HOLD_LEN;
    repeat (16) text.push_back(8'($urandom));
    text.push_back(CH_PERCENT);
    text.push_back(CH_PLUS);                      // two results from one item while full
    send_string(text);
    steady = 1'b0;
  endtask

  task automatic test_random();
    int len;
    while (chars_sent < ITEM_GOAL) begin
      if ($urandom_range(99) < 15) steady = ~steady;
      len = ($urandom_range(99) < 30) ? $urandom_range(3, 1) : $urandom_range(14, 1);
      send_random_string(len, $urandom_range(99) < 15);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
